// ===== rtl/srbf_pkg.sv =====
// ----------------------------------------------------------------------------
// srbf_pkg: shared definitions for the swept rc band-pass filter
// Field widths, register indexes and reset values, datapath op and phase
// codes, and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package srbf_pkg;

  // channel count and index width
  localparam int NUM_CHANNELS = 8;
  localparam int CH_W         = 3;
  localparam int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // field and state widths
  localparam int SAMPLE_W = 32;
  localparam int RC_W     = 36;
  localparam int RATIO_W  = 32;
  localparam int DT_W     = 32;
  localparam int MEM_W    = 48;
  localparam int DEN_W    = RC_W + 1;
  localparam int ALPHA_W  = 33;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 36;

  localparam logic [CFG_IDX_W-1:0] REG_LP_RC_START = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HP_RC_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LP_RATIO    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HP_RATIO    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DT          = 3'd4;

  // reset values
  localparam logic [RC_W-1:0]    LP_RC_RESET = 36'd4375000;
  localparam logic [RC_W-1:0]    HP_RC_RESET = 36'd17499100000;
  localparam logic [RATIO_W-1:0] RATIO_RESET = 32'd1073741824;
  localparam logic [DT_W-1:0]    DT_RESET    = 32'd22906492;

  // alpha of exactly one
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = {1'b1, {(ALPHA_W-1){1'b0}}};

  // datapath operations
  localparam logic [1:0] OP_LP  = 2'd0;
  localparam logic [1:0] OP_HP  = 2'd1;
  localparam logic [1:0] OP_SWL = 2'd2;
  localparam logic [1:0] OP_SWH = 2'd3;

  // phases of one operation
  localparam logic [2:0] PH_SET  = 3'd0;
  localparam logic [2:0] PH_ABS  = 3'd1;
  localparam logic [2:0] PH_MUL0 = 3'd2;
  localparam logic [2:0] PH_MUL1 = 3'd3;
  localparam logic [2:0] PH_MUL2 = 3'd4;
  localparam logic [2:0] PH_FIN  = 3'd5;

  typedef struct packed {
    logic       accept;
    logic       load;
    logic       div_step;
    logic       op_en;
    logic [1:0] op;
    logic [2:0] phase;
    logic       commit;
  } srbf_cmd_t;

  typedef struct packed {
    logic ch_ok;
    logic out_free;
  } srbf_stat_t;

  // channel field to state index
  function automatic logic [IDX_W-1:0] ch_index(input logic [CH_W-1:0] c);
    logic [IDX_W+CH_W-1:0] t;
    t = {{IDX_W{1'b0}}, c};
    return t[IDX_W-1:0];
  endfunction

endpackage

// ===== rtl/srbf_if.sv =====
// ----------------------------------------------------------------------------
// srbf_if: stream interfaces of the swept rc band-pass filter
// Sample request channel and result request channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface srbf_in_if;
  import srbf_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic [CH_W-1:0]            channel;
  logic                       restart;

  modport source (output valid, output sample_in, output channel, output restart,
                  input ready);
  modport sink (input valid, input sample_in, input channel, input restart,
                output ready);
endinterface

interface srbf_out_if;
  import srbf_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic [CH_W-1:0]            out_channel;

  modport source (output valid, output sample_out, output out_channel, input ready);
  modport sink (input valid, input sample_out, input out_channel, output ready);
endinterface

// ===== rtl/swept_rc_bandpass_filter.sv =====
// ----------------------------------------------------------------------------
// swept_rc_bandpass_filter: per-channel swept rc band-pass filter
// One-pole rc low-pass into one-pole rc high-pass, with coefficients derived
// per sample from per-channel time constants that glide by sweep ratios.
//
//   channel     dir   handshake          payload
//   in_stream   in    valid / ready      sample_in, channel, restart
//   out_stream  out   valid / ready      sample_out, out_channel
//   cfg         in    cfg_write only     cfg_index, cfg_data
//
// A sample runs from the accepting edge to the result register through the
// load state, 32 divider steps (both coefficients in parallel, one
// quotient bit a cycle, with the time constant sweeps on the shared
// multiplier meanwhile), the low-pass and high-pass updates through their
// set, abs, multiply and finish phases, and the commit; the next sample
// is taken only once the commit has returned the sequencer to idle.
// A new request is taken while a finished result waits in the output register;
// the commit stalls only while that register is full and not taken.
// Synchronous reset loads the register defaults and channel state at once.
// ----------------------------------------------------------------------------
module swept_rc_bandpass_filter (
  input  logic                            clk,
  input  logic                            rst,
  srbf_in_if.sink                         in_stream,
  srbf_out_if.source                      out_stream,
  input  logic                            cfg_write,
  input  logic [srbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srbf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import srbf_pkg::*;

  srbf_cmd_t  cmd;
  srbf_stat_t stat;

  // sequencer
  srbf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_stream.valid),
    .in_ready(in_stream.ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  // arithmetic, state and output stage
  srbf_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .sample_in  (in_stream.sample_in),
    .channel    (in_stream.channel),
    .restart    (in_stream.restart),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_ready  (out_stream.ready),
    .out_valid  (out_stream.valid),
    .sample_out (out_stream.sample_out),
    .out_channel(out_stream.out_channel)
  );

endmodule

// ===== rtl/srbf_div.sv =====
// ----------------------------------------------------------------------------
// srbf_div: restoring divider for filter coefficients
// Computes floor(num * 2^32 / den), one quotient bit per step, and gives
// exactly one when num is not below den.
// ----------------------------------------------------------------------------
module srbf_div (
  input  logic                          clk,
  input  logic                          start,
  input  logic                          step,
  input  logic [srbf_pkg::RC_W-1:0]     num,
  input  logic [srbf_pkg::DEN_W-1:0]    den,
  output logic [srbf_pkg::ALPHA_W-1:0]  quot
);
  import srbf_pkg::*;

  localparam int Q_W = ALPHA_W - 1;

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [Q_W-1:0]   q;
  logic             one;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   den_x;

  assign rem_sh = {rem, 1'b0};
  assign den_x  = {1'b0, den_r};

  // load operands, then shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= DEN_W'(num);
      den_r <= den;
      q     <= '0;
      one   <= (DEN_W'(num) >= den);
    end else if (step) begin
      if (rem_sh >= den_x) begin
        rem <= DEN_W'(rem_sh - den_x);
        q   <= {q[Q_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DEN_W-1:0];
        q   <= {q[Q_W-2:0], 1'b0};
      end
    end
  end

  assign quot = one ? ALPHA_ONE : {1'b0, q};

endmodule

// ===== rtl/srbf_ctrl.sv =====
// ----------------------------------------------------------------------------
// srbf_ctrl: sequencer of the swept rc band-pass filter
// Steps one sample through coefficient division, time constant sweeps,
// low-pass and high-pass updates, and hands the result to the output stage.
// ----------------------------------------------------------------------------
module srbf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  srbf_pkg::srbf_stat_t stat,
  output srbf_pkg::srbf_cmd_t  cmd
);
  import srbf_pkg::*;

  localparam int DIV_STEPS    = ALPHA_W - 1;
  localparam int CNT_W        = $clog2(DIV_STEPS);
  localparam int SWEEP_CYCLES = 8;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_LP   = 3'd3;
  localparam logic [2:0] S_HP   = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [2:0]       ph, ph_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ph_next    = ph;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load = 1'b1;
        cnt_next = '0;
        if (stat.ch_ok) begin
          state_next = S_DIV;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        // both sweeps share the multiplier while the dividers run
        if (cnt < CNT_W'(SWEEP_CYCLES)) begin
          cmd.op_en = 1'b1;
          cmd.op    = cnt[2] ? OP_SWH : OP_SWL;
          cmd.phase = PH_MUL0 + 3'(cnt[1:0]);
        end
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_LP;
          ph_next    = PH_SET;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      S_LP: begin
        cmd.op_en = 1'b1;
        cmd.op    = OP_LP;
        cmd.phase = ph;
        if (ph == PH_FIN) begin
          state_next = S_HP;
          ph_next    = PH_SET;
        end else begin
          ph_next = ph + 3'd1;
        end
      end
      S_HP: begin
        cmd.op_en = 1'b1;
        cmd.op    = OP_HP;
        cmd.phase = ph;
        if (ph == PH_FIN) begin
          state_next = S_DONE;
          ph_next    = PH_SET;
        end else begin
          ph_next = ph + 3'd1;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      ph    <= PH_SET;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      ph    <= ph_next;
    end
  end

endmodule

// ===== rtl/srbf_dp.sv =====
// ----------------------------------------------------------------------------
// srbf_dp: datapath of the swept rc band-pass filter
// Configuration and per-channel state, two coefficient dividers, one shared
// two-pass multiplier, filter updates with saturation, and the output stage.
// ----------------------------------------------------------------------------
module srbf_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  srbf_pkg::srbf_cmd_t               cmd,
  output srbf_pkg::srbf_stat_t              stat,
  input  logic signed [srbf_pkg::SAMPLE_W-1:0] sample_in,
  input  logic [srbf_pkg::CH_W-1:0]         channel,
  input  logic                              restart,
  input  logic                              cfg_write,
  input  logic [srbf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [srbf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic signed [srbf_pkg::SAMPLE_W-1:0] sample_out,
  output logic [srbf_pkg::CH_W-1:0]         out_channel
);
  import srbf_pkg::*;

  localparam int FRAC_W     = MEM_W - SAMPLE_W;
  localparam int ALPHA_FRAC = ALPHA_W - 1;
  localparam int RATIO_FRAC = 30;
  localparam int CHUNK_W    = 25;
  localparam int A_W        = 2 * CHUNK_W;
  localparam int V_W        = A_W;
  localparam int PROD_W     = CHUNK_W + ALPHA_W;
  localparam int ACC_W      = A_W + ALPHA_W;
  localparam int M_W        = ACC_W - ALPHA_FRAC;
  localparam int S_W        = M_W + 1;
  localparam int Q_W        = M_W - FRAC_W;

  localparam logic [Q_W-1:0] Q_NEG_LIM = Q_W'(1) << (SAMPLE_W - 1);
  localparam logic [Q_W-1:0] Q_POS_LIM = Q_NEG_LIM - Q_W'(1);
  localparam logic signed [SAMPLE_W-1:0] OUT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] OUT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic [RC_W-1:0] RC_MAX = '1;

  // saturate a wide signed value to the filter state width
  function automatic logic signed [MEM_W-1:0] sat_mem(input logic signed [S_W-1:0] val);
    if (val[S_W-1:MEM_W-1] == '0 || val[S_W-1:MEM_W-1] == '1) begin
      return val[MEM_W-1:0];
    end else if (val[S_W-1]) begin
      return {1'b1, {(MEM_W-1){1'b0}}};
    end else begin
      return {1'b0, {(MEM_W-1){1'b1}}};
    end
  endfunction

  // configuration registers
  logic [RC_W-1:0]    lp_rc_start, hp_rc_start;
  logic [RATIO_W-1:0] lp_ratio, hp_ratio;
  logic [DT_W-1:0]    dt;

  always_ff @(posedge clk) begin
    if (rst) begin
      lp_rc_start <= LP_RC_RESET;
      hp_rc_start <= HP_RC_RESET;
      lp_ratio    <= RATIO_RESET;
      hp_ratio    <= RATIO_RESET;
      dt          <= DT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LP_RC_START: lp_rc_start <= cfg_data[RC_W-1:0];
        REG_HP_RC_START: hp_rc_start <= cfg_data[RC_W-1:0];
        REG_LP_RATIO:    lp_ratio    <= cfg_data[RATIO_W-1:0];
        REG_HP_RATIO:    hp_ratio    <= cfg_data[RATIO_W-1:0];
        REG_DT:          dt          <= cfg_data[DT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input request latch
  logic signed [SAMPLE_W-1:0] x_r;
  logic [CH_W-1:0]            ch_r;
  logic                       restart_r;
  logic [IDX_W-1:0]           idx;
  logic                       ch_ok;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r       <= sample_in;
      ch_r      <= channel;
      restart_r <= restart;
    end
  end

  assign idx   = ch_index(ch_r);
  assign ch_ok = (int'(ch_r) < NUM_CHANNELS);

  // per-channel state
  logic signed [MEM_W-1:0] lp_mem [NUM_CHANNELS];
  logic signed [MEM_W-1:0] hp_mem [NUM_CHANNELS];
  logic [RC_W-1:0]         lp_rc_now [NUM_CHANNELS];
  logic [RC_W-1:0]         hp_rc_now [NUM_CHANNELS];

  // working registers
  logic [RC_W-1:0]         rc_lp, rc_hp, rc_lp_new, rc_hp_new;
  logic signed [MEM_W-1:0] lpm_r, hpm_r, lp, hpm_new;
  logic signed [V_W-1:0]   v;
  logic [A_W-1:0]          vmag;
  logic                    vneg;
  logic signed [S_W-1:0]   lp_neg;
  logic [PROD_W-1:0]       prod;
  logic [ACC_W-1:0]        acc;
  logic signed [SAMPLE_W-1:0] res;

  // time constants at load, restart takes the start registers
  logic [RC_W-1:0]    rc_lp_sel, rc_hp_sel;
  logic [DEN_W-1:0]   den_lp, den_hp;
  logic [ALPHA_W-1:0] alpha_lp, alpha_hp;

  assign rc_lp_sel = restart_r ? lp_rc_start : lp_rc_now[idx];
  assign rc_hp_sel = restart_r ? hp_rc_start : hp_rc_now[idx];
  assign den_lp    = DEN_W'(rc_lp_sel) + DEN_W'(dt);
  assign den_hp    = DEN_W'(rc_hp_sel) + DEN_W'(dt);

  srbf_div u_div_lp (
    .clk  (clk),
    .start(cmd.load),
    .step (cmd.div_step),
    .num  (RC_W'(dt)),
    .den  (den_lp),
    .quot (alpha_lp)
  );

  srbf_div u_div_hp (
    .clk  (clk),
    .start(cmd.load),
    .step (cmd.div_step),
    .num  (rc_hp_sel),
    .den  (den_hp),
    .quot (alpha_hp)
  );

  // multiplier operand selection
  logic [A_W-1:0]     a_sel;
  logic [ALPHA_W-1:0] b_sel;
  logic [CHUNK_W-1:0] a_lo, a_hi;

  always_comb begin
    case (cmd.op)
      OP_LP: begin
        a_sel = vmag;
        b_sel = alpha_lp;
      end
      OP_HP: begin
        a_sel = vmag;
        b_sel = alpha_hp;
      end
      OP_SWL: begin
        a_sel = A_W'(rc_lp);
        b_sel = ALPHA_W'(lp_ratio);
      end
      default: begin
        a_sel = A_W'(rc_hp);
        b_sel = ALPHA_W'(hp_ratio);
      end
    endcase
  end

  assign a_lo = a_sel[CHUNK_W-1:0];
  assign a_hi = a_sel[A_W-1:CHUNK_W];

  // finishing arithmetic on the accumulated product
  logic [M_W-1:0]          m;
  logic signed [S_W-1:0]   m_s;
  logic signed [S_W-1:0]   lp_sum, hp_sum;
  logic signed [MEM_W-1:0] x_ext;
  logic [Q_W-1:0]          qmag, qneg;
  logic signed [SAMPLE_W-1:0] q_sat;
  logic [RC_W-1:0]         sweep_sat;

  assign m      = acc[ACC_W-1:ALPHA_FRAC];
  assign m_s    = signed'({1'b0, m});
  assign lp_sum = vneg ? S_W'(lpm_r) - m_s : S_W'(lpm_r) + m_s;
  assign hp_sum = vneg ? lp_neg - m_s : lp_neg + m_s;
  assign x_ext  = {x_r, {FRAC_W{1'b0}}};
  assign qmag   = m[M_W-1:FRAC_W];
  assign qneg   = Q_W'(0) - qmag;

  // output sample, truncated toward zero and saturated
  always_comb begin
    if (!vneg) begin
      q_sat = (qmag > Q_POS_LIM) ? OUT_MAX : qmag[SAMPLE_W-1:0];
    end else begin
      q_sat = (qmag > Q_NEG_LIM) ? OUT_MIN : qneg[SAMPLE_W-1:0];
    end
  end

  // swept time constant, saturated at its maximum
  assign sweep_sat = (acc[ACC_W-1:RATIO_FRAC+RC_W] != '0) ? RC_MAX :
                     acc[RATIO_FRAC+RC_W-1:RATIO_FRAC];

  // load channel state and step the operations
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rc_lp <= rc_lp_sel;
      rc_hp <= rc_hp_sel;
      lpm_r <= lp_mem[idx];
      hpm_r <= hp_mem[idx];
    end
    if (cmd.op_en) begin
      case (cmd.phase)
        PH_SET: begin
          if (cmd.op == OP_LP) begin
            v <= V_W'(x_ext) - V_W'(lpm_r);
          end else begin
            v      <= V_W'(lp) + V_W'(hpm_r);
            lp_neg <= -S_W'(lp);
          end
        end
        PH_ABS: begin
          vneg <= v[V_W-1];
          vmag <= v[V_W-1] ? A_W'(-v) : A_W'(v);
        end
        PH_MUL0: begin
          prod <= PROD_W'(a_lo) * PROD_W'(b_sel);
        end
        PH_MUL1: begin
          acc  <= ACC_W'(prod);
          prod <= PROD_W'(a_hi) * PROD_W'(b_sel);
        end
        PH_MUL2: begin
          acc <= acc + (ACC_W'(prod) << CHUNK_W);
        end
        PH_FIN: begin
          case (cmd.op)
            OP_LP: lp <= sat_mem(lp_sum);
            OP_HP: begin
              hpm_new <= sat_mem(hp_sum);
              res     <= q_sat;
            end
            OP_SWL: rc_lp_new <= sweep_sat;
            default: rc_hp_new <= sweep_sat;
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  // state write-back on commit
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        lp_mem[i]    <= '0;
        hp_mem[i]    <= '0;
        lp_rc_now[i] <= LP_RC_RESET;
        hp_rc_now[i] <= HP_RC_RESET;
      end
    end else if (cmd.commit && ch_ok) begin
      lp_mem[idx]    <= lp;
      hp_mem[idx]    <= hpm_new;
      lp_rc_now[idx] <= rc_lp_new;
      hp_rc_now[idx] <= rc_hp_new;
    end
  end

  // output register
  logic out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (cmd.commit) begin
      out_full <= 1'b1;
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      sample_out  <= ch_ok ? res : '0;
      out_channel <= ch_r;
    end
  end

  assign out_valid     = out_full;
  assign stat.ch_ok    = ch_ok;
  assign stat.out_free = !out_full || out_ready;

endmodule

// ===== tb/srbf_checker.sv =====
// ----------------------------------------------------------------------------
// srbf_checker: result predictor and scoreboard for the swept rc band-pass
// Watches the sample and result request channels and the register write
// port. Keeps its own copy of the registers and per-channel filter state.
// Works out each filtered sample when its request is taken, and compares
// every result request field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module srbf_checker (
  input  logic                            clk,
  input  logic                            rst,
  srbf_in_if                              sample_mon,
  srbf_out_if                             result_mon,
  input  logic                            cfg_write,
  input  logic [srbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srbf_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              errors,
  output int                              outstanding
);
  import srbf_pkg::*;

  localparam logic [RC_W-1:0] RC_FULL = '1;
  localparam longint MEM_HI = 64'sh7FFF_FFFF_FFFF;
  localparam longint MEM_LO = -MEM_HI - 1;
  localparam longint OUT_HI = 64'sd2147483647;
  localparam longint OUT_LO = -64'sd2147483648;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [CH_W-1:0]            channel;
  } filtered_t;

  // register copies
  logic [RC_W-1:0]    lp_tau_start;
  logic [RC_W-1:0]    hp_tau_start;
  logic [RATIO_W-1:0] lp_glide;
  logic [RATIO_W-1:0] hp_glide;
  logic [DT_W-1:0]    dt_step;

  // per-channel filter state
  longint          lp_mem [NUM_CHANNELS];
  longint          hp_mem [NUM_CHANNELS];
  logic [RC_W-1:0] lp_tau [NUM_CHANNELS];
  logic [RC_W-1:0] hp_tau [NUM_CHANNELS];

  filtered_t filtered_q[$];
  filtered_t next_out;
  filtered_t oldest;

  // floor(num * 2^32 / den), exactly one once num reaches den
  function automatic logic [ALPHA_W-1:0] coef(input logic [DEN_W-1:0] num,
                                              input logic [DEN_W-1:0] den);
    logic [DEN_W+31:0] q;
    if (num >= den) return ALPHA_ONE;
    q = {num, 32'd0} / den;
    return q[ALPHA_W-1:0];
  endfunction

  // v * a / 2^32, truncated toward zero
  function automatic longint scale(input longint v, input logic [ALPHA_W-1:0] a);
    logic [63:0] mag;
    logic [96:0] p;
    mag = (v < 0) ? -v : v;
    p = mag * a;
    return (v < 0) ? -longint'(p[95:32]) : longint'(p[95:32]);
  endfunction

  function automatic longint clamp48(input longint v);
    if (v > MEM_HI) return MEM_HI;
    if (v < MEM_LO) return MEM_LO;
    return v;
  endfunction

  // time constant times UQ2.30 ratio, floored, pinned at full scale
  function automatic logic [RC_W-1:0] glide(input logic [RC_W-1:0] rc,
                                            input logic [RATIO_W-1:0] ratio);
    logic [RC_W+RATIO_W-1:0] p;
    p = rc * ratio;
    if (p[RC_W+RATIO_W-1:30] > RC_FULL) return RC_FULL;
    return p[RC_W+29:30];
  endfunction

  // low-pass then high-pass on one sample, then sweep that channel
  task automatic filter_sample(input logic signed [SAMPLE_W-1:0] smp,
                               input logic [CH_W-1:0] ch, input logic rs,
                               output filtered_t res);
    int i;
    logic [DEN_W-1:0] dt;
    logic [ALPHA_W-1:0] a_lp;
    logic [ALPHA_W-1:0] a_hp;
    longint x;
    longint lp;
    longint s;
    longint q;
    res.channel = ch;
    res.sample = '0;
    if (int'(ch) >= NUM_CHANNELS) return;
    i = int'(ch);
    if (rs) begin
      lp_tau[i] = lp_tau_start;
      hp_tau[i] = hp_tau_start;
    end
    dt = DEN_W'(dt_step);
    a_lp = coef(dt, DEN_W'(lp_tau[i]) + dt);
    a_hp = coef(DEN_W'(hp_tau[i]), DEN_W'(hp_tau[i]) + dt);
    lp_tau[i] = glide(lp_tau[i], lp_glide);
    hp_tau[i] = glide(hp_tau[i], hp_glide);
    x = longint'(smp) * 65536;
    lp = clamp48(lp_mem[i] + scale(x - lp_mem[i], a_lp));
    lp_mem[i] = lp;
    s = scale(lp + hp_mem[i], a_hp);
    hp_mem[i] = clamp48(s - lp);
    q = s / 65536;
    if (q > OUT_HI) q = OUT_HI;
    else if (q < OUT_LO) q = OUT_LO;
    res.sample = q[SAMPLE_W-1:0];
  endtask

  task automatic flag(input string msg);
    errors++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      lp_tau_start = LP_RC_RESET;
      hp_tau_start = HP_RC_RESET;
      lp_glide = RATIO_RESET;
      hp_glide = RATIO_RESET;
      dt_step = DT_RESET;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        lp_mem[c] = 0;
        hp_mem[c] = 0;
        lp_tau[c] = LP_RC_RESET;
        hp_tau[c] = HP_RC_RESET;
      end
      filtered_q.delete();
      errors = 0;
    end else begin
      // register writes
      if (cfg_write) begin
        case (cfg_index)
          REG_LP_RC_START: lp_tau_start = cfg_data[RC_W-1:0];
          REG_HP_RC_START: hp_tau_start = cfg_data[RC_W-1:0];
          REG_LP_RATIO:    lp_glide = cfg_data[RATIO_W-1:0];
          REG_HP_RATIO:    hp_glide = cfg_data[RATIO_W-1:0];
          REG_DT:          dt_step = cfg_data[DT_W-1:0];
          default: ;
        endcase
      end
      // result request against the oldest prediction
      if (result_mon.valid && result_mon.ready) begin
        if (filtered_q.size() == 0) begin
          flag($sformatf("result %0d on channel %0d with no sample waiting",
                         result_mon.sample_out, result_mon.out_channel));
        end else begin
          oldest = filtered_q.pop_front();
          if (result_mon.sample_out !== oldest.sample)
            flag($sformatf("sample_out %0d, predicted %0d (channel %0d)",
                           result_mon.sample_out, oldest.sample, oldest.channel));
          if (result_mon.out_channel !== oldest.channel)
            flag($sformatf("out_channel %0d, predicted %0d",
                           result_mon.out_channel, oldest.channel));
        end
      end
      // sample request taken
      if (sample_mon.valid && sample_mon.ready) begin
        filter_sample(sample_mon.sample_in, sample_mon.channel, sample_mon.restart,
                      next_out);
        filtered_q.push_back(next_out);
      end
    end
    outstanding <= filtered_q.size();
  end

endmodule

// ===== tb/swept_rc_bandpass_filter_tb.sv =====
// ----------------------------------------------------------------------------
// swept_rc_bandpass_filter_tb: stimulus and verdict for the band-pass filter
// Drives sample requests and register writes, stalls the result side at
// random, and leaves all checking to srbf_checker. A directed opening covers
// field extremes, saturation, collapsed time constants and a zero sample
// period; random phases follow under a series of filter settings.
// ----------------------------------------------------------------------------
module swept_rc_bandpass_filter_tb;
  import srbf_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 150;
  localparam int NUM_PHASES  = 7;
  localparam logic [RC_W-1:0] RC_FULL = '1;
  localparam logic [SAMPLE_W-1:0] S_MAX = 32'h7FFF_FFFF;
  localparam logic [SAMPLE_W-1:0] S_MIN = 32'h8000_0000;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors;
  int                    outstanding;

  // shared between stimulus and result-side processes
  bit lulls_on;
  bit hold_request;
  int items_sent;
  int restarts;
  int settings;
  int unsigned cycle_count;

  srbf_in_if  sample_req ();
  srbf_out_if result_req ();

  swept_rc_bandpass_filter dut (
    .clk        (clk),
    .rst        (rst),
    .in_stream  (sample_req),
    .out_stream (result_req),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  srbf_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .sample_mon  (sample_req),
    .result_mon  (result_req),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // cycle limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still due", cycle_count, outstanding);
    $display("*** FAILED ***");
    $finish;
  end

  // result side: random stall bursts plus one long hold on request
  initial begin
    int stall_left;
    stall_left = 0;
    result_req.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        stall_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end else if (stall_left == 0 && lulls_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 14);
      end
      if (stall_left > 0) begin
        result_req.ready <= 1'b0;
        stall_left--;
      end else begin
        result_req.ready <= 1'b1;
      end
    end
  end

  function automatic logic [RC_W-1:0] rand_rc(input int lo_bits, input int hi_bits);
    logic [RC_W-1:0] span;
    int n;
    case ($urandom_range(0, 9))
      0: return 36'd1;
      1: return RC_FULL;
      2: return {4'($urandom_range(0, 15)), $urandom};
      default: begin
        n = $urandom_range(lo_bits, hi_bits);
        span = (36'd1 << n);
        return span | (RC_W'({$urandom_range(0, 15), $urandom}) & (span - 36'd1));
      end
    endcase
  endfunction

  // mostly gentle glides around unity, sometimes the extremes
  function automatic logic [RATIO_W-1:0] rand_ratio();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return $urandom;
      default: return RATIO_RESET + 32'($urandom_range(0, 2097152)) - 32'd1048576;
    endcase
  endfunction

  function automatic logic [DT_W-1:0] rand_dt();
    case ($urandom_range(0, 7))
      0: return 32'd1;
      1: return '1;
      2: return $urandom;
      default: return (32'd1 << $urandom_range(18, 28)) | 32'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return S_MAX;
      1: return S_MIN;
      2: return 32'($urandom_range(0, 511)) - 32'd256;
      default: return $urandom;
    endcase
  endfunction

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
  endtask

  // full register set, junk in the unused upper bits and one stray index
  task automatic apply_setting(input logic [RC_W-1:0] lp_start, input logic [RC_W-1:0] hp_start,
                               input logic [RATIO_W-1:0] lp_ratio,
                               input logic [RATIO_W-1:0] hp_ratio,
                               input logic [DT_W-1:0] dt);
    put_reg(REG_LP_RC_START, lp_start);
    put_reg(REG_HP_RC_START, hp_start);
    put_reg(REG_LP_RATIO, {4'($urandom_range(0, 15)), lp_ratio});
    put_reg(REG_HP_RATIO, {4'($urandom_range(0, 15)), hp_ratio});
    put_reg(REG_DT, {4'($urandom_range(0, 15)), dt});
    put_reg(REG_DT + CFG_IDX_W'($urandom_range(1, 3)), {4'($urandom_range(0, 15)), $urandom});
    cfg_write <= 1'b0;
    settings++;
  endtask

  // one sample request, with an optional idle burst ahead of it
  task automatic offer(input logic [SAMPLE_W-1:0] smp, input logic [CH_W-1:0] ch,
                       input logic rs);
    int gap;
    if (lulls_on && $urandom_range(0, 3) == 0) begin
      sample_req.valid <= 1'b0;
      gap = $urandom_range(1, 14);
      repeat (gap) @(posedge clk);
    end
    sample_req.valid <= 1'b1;
    sample_req.sample_in <= smp;
    sample_req.channel <= ch;
    sample_req.restart <= rs;
    items_sent++;
    if (rs) restarts++;
    do @(posedge clk); while (!sample_req.ready);
  endtask

  // stop offering and wait for every predicted result
  task automatic drain();
    sample_req.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic run_phase(input int count, input bit with_hold, input bit with_pause);
    int k;
    for (k = 0; k < count; k++) begin
      if (with_hold && k == 5) hold_request = 1'b1;
      if (with_pause && k == count / 2) drain();
      offer(rand_sample(), CH_W'($urandom_range(0, (1 << CH_W) - 1)),
            $urandom_range(0, 15) == 0);
    end
  endtask

  initial begin
    int ph;
    sample_req.valid <= 1'b0;
    sample_req.sample_in <= '0;
    sample_req.channel <= '0;
    sample_req.restart <= 1'b0;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    rst <= 1'b1;
    lulls_on = 1'b1;
    hold_request = 1'b0;
    items_sent = 0;
    restarts = 0;
    settings = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset coefficients: sample extremes across all channels
    offer(S_MAX, 3'd0, 1'b0);
    offer(S_MIN, 3'd1, 1'b1);
    offer('0, 3'd2, 1'b0);
    offer('1, 3'd3, 1'b1);
    offer(32'd1, 3'd4, 1'b0);
    offer(S_MAX, 3'd5, 1'b0);
    offer(S_MIN, 3'd6, 1'b0);
    offer(S_MAX, 3'd7, 1'b1);

    // register extremes, time constants sweep up into saturation
    drain();
    apply_setting(RC_FULL, 36'd1, '1, '1, '1);
    offer(S_MAX, 3'd0, 1'b1);
    offer(S_MIN, 3'd0, 1'b0);
    offer(S_MAX, 3'd0, 1'b0);

    // near-unity coefficients, full-scale swings saturate the output
    drain();
    apply_setting(36'd1, RC_FULL, RATIO_RESET, RATIO_RESET, 32'd1048576);
    offer(S_MAX, 3'd1, 1'b1);
    offer(S_MIN, 3'd1, 1'b0);
    offer(S_MAX, 3'd1, 1'b0);
    offer(S_MIN, 3'd1, 1'b0);

    // zero ratios: time constants collapse after one sample
    drain();
    apply_setting(LP_RC_RESET, HP_RC_RESET, '0, '0, DT_RESET);
    offer(S_MAX, 3'd2, 1'b1);
    offer(32'd12345, 3'd2, 1'b0);
    offer(S_MIN, 3'd2, 1'b0);

    // zero sample period, then zero denominator once collapsed
    drain();
    apply_setting(36'd1000, 36'd1000, '0, '0, '0);
    offer(32'd777777, 3'd3, 1'b1);
    offer(S_MIN, 3'd3, 1'b0);
    offer(S_MAX, 3'd3, 1'b0);

    // random phases, each under its own setting
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      lulls_on = (ph != 3) && (ph < NUM_PHASES - 1);
      apply_setting(rand_rc(14, 30), rand_rc(24, 35), rand_ratio(), rand_ratio(), rand_dt());
      run_phase(PHASE_ITEMS, ph == 1, ph == 2);
    end
    drain();
    repeat (64) @(posedge clk);

    $display("covered %0d samples (%0d with restart) under %0d register settings",
             items_sent, restarts, settings);
    $display("one %0d-cycle result hold and one mid-phase drain included", HOLD_CYCLES);
    if (errors == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, outstanding);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
